// ===== rtl/fba_pkg.sv =====
// Package for filter_bank_argmax_3x3: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;
  localparam int unsigned Taps = 9;
  localparam logic [0:0] ModeCoef  = 1'b0;
  localparam logic [0:0] ModePixel = 1'b1;
  localparam logic [0:0] CfgRowWidth    = 1'b0;
  localparam logic [0:0] CfgFilterCount = 1'b1;
  typedef logic signed [15:0] sample_t;
endpackage
`default_nettype wire

// ===== rtl/filter_bank_argmax_3x3.sv =====
// filter_bank_argmax_3x3: 3x3 filter-bank correlator with argmax search.
// Depends on fba_pkg. Line store and filter bank held in internal memories.
//
// Channel  Dir  Handshake              Payload
// s_axis   in   tvalid/tready          tdata, tuser = mode
// m_axis   out  tvalid/tready          tdata = best_index, best_magnitude
// cfg      in   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// A coefficient load writes one tap of the filter bank. A pixel passes
// through the line store read-modify-write, then, when it is interior,
// through the search: one filter bank row (nine taps) is read per cycle and
// fed to nine multipliers, then a sum stage and a compare stage.
// Reset clears control, counters and window; memories are undefined.
// A pending result blocks the next pixel's search until taken.
`timescale 1ns / 1ps
`default_nettype none
module filter_bank_argmax_3x3 #(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned MAX_FILTERS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata low->high: pixel_value[15:0], frame_start, coef_filter[6:0],
  // coef_tap[3:0], coef_value[15:0], zero pad
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,   // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata low->high: best_index[6:0], best_magnitude[33:0], zero pad
  output logic [47:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned FW = $clog2(MAX_FILTERS + 1);
  localparam int unsigned IW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLine = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0] st_q, st_d;
  logic [10:0] row_width_q;
  logic [7:0]  filter_count_q;

  fba_pkg::sample_t px_in, coef_in;
  logic fs_in;
  logic [6:0] cf_in;
  logic [3:0] ct_in;
  assign px_in   = s_axis_tdata[15:0];
  assign fs_in   = s_axis_tdata[16];
  assign cf_in   = s_axis_tdata[23:17];
  assign ct_in   = s_axis_tdata[27:24];
  assign coef_in = s_axis_tdata[43:28];

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= 11'd1024;
      filter_count_q <= 8'd128;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fba_pkg::CfgRowWidth:    row_width_q    <= cfg_data_i;
        fba_pkg::CfgFilterCount: filter_count_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_eff;
  logic [FW-1:0] n_eff;
  always_comb begin
    if (row_width_q < 11'd3) w_eff = CW'(3);
    else if (32'(row_width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(row_width_q);
    if (filter_count_q == 8'd0) n_eff = FW'(1);
    else if (32'(filter_count_q) > MAX_FILTERS) n_eff = FW'(MAX_FILTERS);
    else n_eff = FW'(filter_count_q);
  end

  // Filter bank: one row of nine taps per filter, byte-lane style tap writes.
  logic [16*fba_pkg::Taps-1:0] fb_mem [MAX_FILTERS];
  logic [16*fba_pkg::Taps-1:0] fb_rd_q;
  logic [IW-1:0] fb_raddr;
  logic fb_we;
  assign fb_we = (st_q == StIdle) && s_axis_tvalid && s_axis_tuser == fba_pkg::ModeCoef
                 && 32'(ct_in) < fba_pkg::Taps && 32'(cf_in) < MAX_FILTERS;
  always_ff @(posedge clk_i) begin
    if (fb_we) fb_mem[IW'(cf_in)][16*ct_in +: 16] <= coef_in;
    fb_rd_q <= fb_mem[fb_raddr];
  end

  // Line store: two rows packed in one entry per column.
  logic [31:0] ls_mem [MAX_WIDTH];
  logic [31:0] ls_rd_q;
  logic [AW-1:0] col_addr;
  logic ls_rd, ls_we;
  logic [31:0] ls_wd;
  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[col_addr] <= ls_wd;
    if (ls_rd) ls_rd_q <= ls_mem[col_addr];
  end

  logic [CW-1:0] col_q, col_cur, col_d;
  logic [1:0] row_q, row_d, row_cur;
  fba_pkg::sample_t px_q;
  fba_pkg::sample_t win_q [fba_pkg::Taps];
  logic emit_q;

  always_comb begin
    col_cur = fs_in ? '0 : col_q;
    row_cur = fs_in ? 2'd0 : row_q;
    if (col_cur >= w_eff) col_cur = '0;
  end

  always_comb begin
    col_d = col_q + CW'(1);
    row_d = row_q;
    if (col_d >= w_eff) begin
      col_d = '0;
      if (row_q != 2'd2) row_d = row_q + 2'd1;
    end
  end

  logic accept;
  assign s_axis_tready = (st_q == StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ls_rd = accept;
  assign ls_we = (st_q == StLine);
  assign ls_wd = {ls_rd_q[15:0], px_q};
  assign col_addr = ls_we ? col_q[AW-1:0] : col_cur[AW-1:0];

  // Search pipeline
  logic [IW:0] f_q;          // filter being read
  logic v1_q, v2_q, v3_q;    // rd data, products, sum valid
  logic [IW-1:0] i1_q, i2_q, i3_q;
  logic signed [31:0] prod_q [fba_pkg::Taps];
  logic [33:0] mag_q;
  logic [33:0] best_mag_q;
  logic [IW-1:0] best_idx_q;
  logic out_v_q;
  assign fb_raddr = f_q[IW-1:0];

  logic signed [35:0] sum;
  always_comb begin
    sum = '0;
    for (int t = 0; t < fba_pkg::Taps; t++) sum = sum + 36'(prod_q[t]);
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (accept && s_axis_tuser == fba_pkg::ModePixel) st_d = StLine;
      StLine: st_d = emit_q ? ((out_v_q) ? StOut : StRun) : StIdle;
      StOut:  if (!out_v_q) st_d = StRun;
      StRun:  if (v3_q && !v2_q && !v1_q && f_q == (IW+1)'(n_eff)) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      col_q <= '0;
      row_q <= '0;
      emit_q <= 1'b0;
      for (int t = 0; t < fba_pkg::Taps; t++) win_q[t] <= '0;
      f_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      i1_q <= '0; i2_q <= '0; i3_q <= '0;
      best_mag_q <= '0;
      best_idx_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept && s_axis_tuser == fba_pkg::ModePixel) begin
        col_q <= col_cur;
        row_q <= row_cur;
        emit_q <= (row_cur == 2'd2) && (col_cur >= CW'(2));
      end
      if (st_q == StLine) begin
        for (int r = 0; r < 3; r++) begin
          win_q[3*r]   <= win_q[3*r+1];
          win_q[3*r+1] <= win_q[3*r+2];
        end
        win_q[2] <= ls_rd_q[31:16];
        win_q[5] <= ls_rd_q[15:0];
        win_q[8] <= px_q;
        col_q <= col_d;
        row_q <= row_d;
        f_q <= '0;
      end
      v1_q <= (st_q == StRun) && (f_q < (IW+1)'(n_eff));
      i1_q <= f_q[IW-1:0];
      if ((st_q == StRun) && (f_q < (IW+1)'(n_eff))) f_q <= f_q + 1'b1;
      v2_q <= v1_q; i2_q <= i1_q;
      v3_q <= v2_q; i3_q <= i2_q;
      if (v3_q) begin
        if (i3_q == '0 || mag_q > best_mag_q) begin
          best_mag_q <= mag_q;
          best_idx_q <= i3_q;
        end
      end
      if (v3_q && st_d == StIdle) out_v_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) px_q <= px_in;
    for (int t = 0; t < fba_pkg::Taps; t++)
      prod_q[t] <= win_q[t] * $signed(fb_rd_q[16*t +: 16]);
    mag_q <= sum[35] ? 34'(-sum) : 34'(sum);
  end

  // Best registers hold the result; the last compare lands with out_v_q.
  logic [33:0] res_mag;
  logic [6:0]  res_idx;
  assign res_mag = best_mag_q;
  assign res_idx = 7'(best_idx_q);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {7'd0, res_mag, res_idx};

  a_fb_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRun) |-> !fb_we) else $error("filter bank written during search");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (st_q == StIdle)) else $error("ready outside idle");
endmodule
`default_nettype wire

// ===== sim/filter_bank_argmax_3x3_test.sv =====
// Testbench for filter_bank_argmax_3x3: directed table, then random frames.
// Self-checking against a behavioral correlator/argmax predictor; needs fba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module filter_bank_argmax_3x3_test;

  localparam int MaxWidth = 1024;
  localparam int MaxFilters = 128;

  typedef struct packed {
    logic        mode;
    logic [15:0] pix;
    logic        sof;
    logic [6:0]  filt;
    logic [3:0]  tap;
    logic [15:0] coef;
    logic        has_exp;
    logic [6:0]  exp_idx;
    logic [33:0] exp_mag;
  } row_t;

  typedef struct packed {
    logic [6:0]  idx;
    logic [33:0] mag;
  } best_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  filter_bank_argmax_3x3 u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fba_pkg::sample_t lines [2*MaxWidth];
  fba_pkg::sample_t win [fba_pkg::Taps];
  fba_pkg::sample_t bank [MaxFilters*fba_pkg::Taps];
  int unsigned col, rows, width_reg, nfilt_reg;
  best_t best_q [$];
  int errors = 0;
  int src_idle = 0, snk_idle = 0;

  function automatic void load_coef(logic [6:0] f, logic [3:0] t, logic [15:0] v);
    if (t < fba_pkg::Taps) bank[f*fba_pkg::Taps + t] = v;
  endfunction

  // returns 1 and best when an interior pixel completes a window
  function automatic bit push_pixel(logic [15:0] v, logic sof, output best_t best);
    int unsigned w, n, c;
    fba_pkg::sample_t top, mid;
    longint acc;
    logic [33:0] mag;
    bit hit;
    best = '0;
    w = width_reg < 3 ? 3 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    n = nfilt_reg < 1 ? 1 : (nfilt_reg > MaxFilters ? MaxFilters : nfilt_reg);
    if (sof) begin
      col = 0;
      rows = 0;
    end
    if (col >= w) col = 0;
    c = col;
    top = lines[MaxWidth + c];
    mid = lines[c];
    lines[MaxWidth + c] = mid;
    lines[c] = v;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = v;
    hit = rows >= 2 && c >= 2;
    col = c + 1;
    if (col >= w) begin
      col = 0;
      if (rows < 2) rows++;
    end
    if (!hit) return 0;
    for (int f = 0; f < n; f++) begin
      acc = 0;
      for (int t = 0; t < fba_pkg::Taps; t++)
        acc += longint'(win[t]) * longint'(bank[f*fba_pkg::Taps + t]);
      mag = 34'(acc < 0 ? -acc : acc);
      if (f == 0 || mag > best.mag) begin
        best.mag = mag;
        best.idx = 7'(f);
      end
    end
    return 1;
  endfunction

  task automatic send(logic mode, logic [15:0] pix, logic sof, logic [6:0] f,
                      logic [3:0] t, logic [15:0] cv, bit forced, best_t fexp);
    best_t b;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser <= mode;
    s_axis_tdata <= {4'd0, cv, t, f, sof, pix};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (mode == fba_pkg::ModeCoef) load_coef(f, t, cv);
    else if (push_pixel(pix, sof, b)) best_q.push_back(forced ? fexp : b);
    @(negedge clk_i);
  endtask

  task automatic pixel(logic [15:0] v, logic sof);
    send(fba_pkg::ModePixel, v, sof, 7'($urandom), 4'($urandom), 16'($urandom),
         1'b0, '0);
  endtask

  task automatic coef(int f, int t, logic [15:0] v);
    send(fba_pkg::ModeCoef, 16'($urandom), 1'($urandom), 7'(f), 4'(t), v, 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (best_q.size() != 0) @(negedge clk_i);
    repeat (MaxFilters + 20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [10:0] v);
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == fba_pkg::CfgRowWidth) width_reg = v;
    else nfilt_reg = v[7:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_bank(int n, bit extreme);
    for (int f = 0; f < n; f++)
      for (int t = 0; t < fba_pkg::Taps; t++)
        coef(f, t, extreme ? ($urandom_range(1) ? 16'h8000 : 16'h7fff) : 16'($urandom));
  endtask

  task automatic frame(int w, int h, int kind);
    logic [15:0] v;
    for (int i = 0; i < w*h; i++) begin
      case (kind)
        0: v = 16'($urandom);
        1: v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
        default: v = 16'($signed($urandom_range(64)) - 32);
      endcase
      pixel(v, i == 0);
    end
  endtask

  always @(negedge clk_i) m_axis_tready <= $urandom_range(99) >= snk_idle;

  always @(posedge clk_i) begin
    best_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.idx = m_axis_tdata[6:0];
      got.mag = m_axis_tdata[40:7];
      if (best_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual idx=%0d mag=%0d",
                 $time, got.idx, got.mag);
        errors++;
      end else begin
        want = best_q.pop_front();
        if (got.idx !== want.idx || got.mag !== want.mag) begin
          $display("%0t mismatch: expected idx=%0d mag=%0d, actual idx=%0d mag=%0d",
                   $time, want.idx, want.mag, got.idx, got.mag);
          errors++;
        end
      end
    end
  end

  row_t dir_rows [$];

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    width_reg = MaxWidth;
    nfilt_reg = MaxFilters;
    col = 0;
    rows = 0;
    foreach (win[i]) win[i] = '0;
    foreach (lines[i]) lines[i] = '0;
    foreach (bank[i]) bank[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: 3x3 frame, two filters; the single interior pixel checked by hand
    write_reg(fba_pkg::CfgRowWidth, 11'd3);
    write_reg(fba_pkg::CfgFilterCount, 11'd2);
    for (int t = 0; t < fba_pkg::Taps; t++) begin
      dir_rows.push_back({fba_pkg::ModeCoef, 16'h0, 1'b0, 7'd0, 4'(t), 16'h8000,
                          1'b0, 7'd0, 34'd0});
      dir_rows.push_back({fba_pkg::ModeCoef, 16'h0, 1'b0, 7'd1, 4'(t), 16'h7fff,
                          1'b0, 7'd0, 34'd0});
    end
    // out-of-range tap is ignored
    dir_rows.push_back({fba_pkg::ModeCoef, 16'h0, 1'b0, 7'd0, 4'd15, 16'h1234,
                        1'b0, 7'd0, 34'd0});
    for (int i = 0; i < 9; i++)
      dir_rows.push_back({fba_pkg::ModePixel, 16'h8000, 1'(i == 0), 7'h7f, 4'hf, 16'hffff,
                          1'(i == 8), 7'd0, 34'd9663676416});
    foreach (dir_rows[i]) begin
      best_t e;
      e.idx = dir_rows[i].exp_idx;
      e.mag = dir_rows[i].exp_mag;
      send(dir_rows[i].mode, dir_rows[i].pix, dir_rows[i].sof, dir_rows[i].filt,
           dir_rows[i].tap, dir_rows[i].coef, dir_rows[i].has_exp, e);
    end
    // all-zero responses: first filter wins with zero
    drain();
    for (int i = 0; i < 9; i++) pixel(16'h0, i == 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = ph == 0 ? 8 : (ph == 1 ? 45 : 0);
      snk_idle = ph == 0 ? 45 : (ph == 1 ? 8 : 0);
      case (ph)
        0: begin
          write_reg(fba_pkg::CfgRowWidth, 11'd0);     // acts as 3
          write_reg(fba_pkg::CfgFilterCount, 11'd0);  // acts as 1
          load_bank(1, 1);
          frame(3, 4, 1);
          drain();
          write_reg(fba_pkg::CfgRowWidth, 11'd5);
          write_reg(fba_pkg::CfgFilterCount, 11'd4);
          load_bank(4, 0);
          frame(5, 4, 0);
        end
        1: begin
          write_reg(fba_pkg::CfgRowWidth, 11'd5);
          write_reg(fba_pkg::CfgFilterCount, 11'd255); // acts as max
          load_bank(MaxFilters, 0);
          frame(5, 3, 0);
          drain();
          write_reg(fba_pkg::CfgFilterCount, 11'd6);
          frame(5, 4, 2);
        end
        default: begin
          write_reg(fba_pkg::CfgRowWidth, 11'd4);
          write_reg(fba_pkg::CfgFilterCount, 11'd8);
          coef(127, 8, 16'h7fff);
          for (int k = 0; k < 4; k++) begin
            coef($urandom_range(7), $urandom_range(8), 16'($urandom));
            frame(4, 4, k % 3);
          end
        end
      endcase
      drain();
    end

    if (errors == 0 && best_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filter_bank_argmax_3x3.f =====
rtl/fba_pkg.sv
rtl/filter_bank_argmax_3x3.sv
sim/filter_bank_argmax_3x3_test.sv
